// ----- src/dsf_pkg.sv -----
// ----------------------------------------------------------------------------
// dsf_pkg
// shared constants, codes and types of the deadband sample filter
// ----------------------------------------------------------------------------
package dsf_pkg;

    // sample width default and fixed field widths
    localparam int SAMPLE_BITS_DEFAULT = 10;
    localparam int CFG_BITS            = 10;
    localparam int PERCENT_BITS        = 7;

    // percent scaling
    localparam int PERCENT_SCALE = 100;
    localparam logic [PERCENT_BITS-1:0] PERCENT_MAX = 7'd100;

    // register reset values
    localparam logic [CFG_BITS-1:0] TOLERANCE_RESET  = 10'd90;
    localparam logic [CFG_BITS-1:0] JUMP_LIMIT_RESET = 10'd300;

    // apb geometry
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // operation codes
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    // register indexes, taken from paddr[2]
    localparam logic REG_TOLERANCE  = 1'b0;
    localparam logic REG_JUMP_LIMIT = 1'b1;

    // configuration handed from the register file to the datapath
    typedef struct packed {
        logic [CFG_BITS-1:0] tolerance;
        logic [CFG_BITS-1:0] jump_limit;
    } dsf_cfg_t;

endpackage

// ----- src/dsf_in_if.sv -----
// ----------------------------------------------------------------------------
// dsf_in_if
// input channel: one operation beat with its sample
// ----------------------------------------------------------------------------
interface dsf_in_if #(
    parameter int SAMPLE_BITS = 10
);
    logic                   valid;
    logic                   ready;
    logic                   operation;
    logic [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output operation, output sample, input ready);
    modport sink   (input valid, input operation, input sample, output ready);
endinterface

// ----- src/dsf_out_if.sv -----
// ----------------------------------------------------------------------------
// dsf_out_if
// result channel: held reading, flags and percent of full scale
// ----------------------------------------------------------------------------
interface dsf_out_if #(
    parameter int SAMPLE_BITS = 10
);
    import dsf_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [SAMPLE_BITS-1:0]  held_reading;
    logic                    reading_valid;
    logic                    changed;
    logic [PERCENT_BITS-1:0] percent;

    modport source (
        output valid, output held_reading, output reading_valid,
        output changed, output percent, input ready
    );
    modport sink (
        input valid, input held_reading, input reading_valid,
        input changed, input percent, output ready
    );
endinterface

// ----- src/dsf_apb_regs.sv -----
// ----------------------------------------------------------------------------
// dsf_apb_regs
// apb register file holding tolerance and jump limit
// ----------------------------------------------------------------------------
module dsf_apb_regs (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dsf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [dsf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [dsf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready,
    output dsf_pkg::dsf_cfg_t                 cfg
);
    import dsf_pkg::*;

    logic [CFG_BITS-1:0] tolerance_reg;
    logic [CFG_BITS-1:0] jump_limit_reg;
    logic                wr_en;

    // no wait states
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // register writes, word index in paddr[2]
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg  <= TOLERANCE_RESET;
            jump_limit_reg <= JUMP_LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (paddr[2])
                REG_TOLERANCE:  tolerance_reg  <= pwdata[CFG_BITS-1:0];
                REG_JUMP_LIMIT: jump_limit_reg <= pwdata[CFG_BITS-1:0];
                default:        tolerance_reg  <= tolerance_reg;
            endcase
        end
    end

    // read mux
    always_comb
    begin
        unique case (paddr[2])
            REG_TOLERANCE:  prdata = APB_DATA_BITS'(tolerance_reg);
            REG_JUMP_LIMIT: prdata = APB_DATA_BITS'(jump_limit_reg);
            default:        prdata = '0;
        endcase
    end

    assign cfg.tolerance  = tolerance_reg;
    assign cfg.jump_limit = jump_limit_reg;

endmodule

// ----- src/deadband_sample_filter_top.sv -----
// ----------------------------------------------------------------------------
// deadband_sample_filter_top
// deadband filter with jump confirmation over converter samples
// ----------------------------------------------------------------------------
//  channel     dir  handshake            payload
//  sample_ch   in   valid/ready          operation, sample
//  result_ch   out  valid/ready          held_reading, reading_valid, changed, percent
//  apb         in   psel/penable/pready  paddr, pwdata, prdata
//
//  one beat per cycle while the result register is free or draining; the held-value update is a single register loop
//  a sample beat gives its result in the cycle after acceptance; a clear beat gives none
//  the result register accepts a new beat while the current result is being taken
//  a stalled result blocks input only when the result register is full
//  reset clears the held value, state flags and result valid, and sets the apb registers to their defaults
// ----------------------------------------------------------------------------
module deadband_sample_filter_top #(
    parameter int SAMPLE_BITS = dsf_pkg::SAMPLE_BITS_DEFAULT
) (
    input  logic                              clk,
    input  logic                              rst_n,
    dsf_in_if.sink                            sample_ch,
    dsf_out_if.source                         result_ch,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dsf_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [dsf_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [dsf_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                              pready
);
    import dsf_pkg::*;

    localparam int FULL_SCALE = (1 << SAMPLE_BITS) - 1;
    localparam int CMP_BITS   = (SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS;
    localparam int PROD_BITS  = SAMPLE_BITS + PERCENT_BITS;
    localparam int REM_BITS   = SAMPLE_BITS + 1;

    dsf_cfg_t cfg;

    // filter state
    logic [SAMPLE_BITS-1:0] held_value_reg, held_value_next;
    logic                   held_valid_reg, held_valid_next;
    logic                   pending_reg,    pending_next;
    logic                   change_reg,     change_next;

    // result register
    logic                    out_valid_reg;
    logic [SAMPLE_BITS-1:0]  out_held_reg;
    logic                    out_rvalid_reg;
    logic                    out_changed_reg;
    logic [PERCENT_BITS-1:0] out_percent_reg;

    logic                   in_acc;
    logic                   sample_acc;
    logic                   clear_acc;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   over_tol;
    logic                   over_jump;

    logic [PROD_BITS-1:0]    scaled;
    logic [PERCENT_BITS-1:0] pct_coarse;
    logic [REM_BITS-1:0]     pct_rem;
    logic [PERCENT_BITS-1:0] pct_next;

    dsf_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input is taken whenever the result register is free or draining
    assign sample_ch.ready = !out_valid_reg || result_ch.ready;
    assign in_acc          = sample_ch.valid && sample_ch.ready;
    assign sample_acc      = in_acc && (sample_ch.operation == OP_SAMPLE);
    assign clear_acc       = in_acc && (sample_ch.operation == OP_CLEAR);

    // distance from the held value
    assign diff = (sample_ch.sample > held_value_reg) ? sample_ch.sample - held_value_reg
                                                      : held_value_reg - sample_ch.sample;
    assign over_tol  = CMP_BITS'(diff) > CMP_BITS'(cfg.tolerance);
    assign over_jump = CMP_BITS'(diff) > CMP_BITS'(cfg.jump_limit);

    // adoption decision
    always_comb
    begin
        held_value_next = held_value_reg;
        held_valid_next = held_valid_reg;
        pending_next    = pending_reg;
        change_next     = change_reg;
        if (clear_acc)
        begin
            change_next = 1'b0;
        end
        else if (sample_acc)
        begin
            if (!held_valid_reg || pending_reg || (over_tol && !over_jump))
            begin
                held_value_next = sample_ch.sample;
                held_valid_next = 1'b1;
                change_next     = 1'b1;
                pending_next    = 1'b0;
            end
            else if (over_tol)
            begin
                pending_next = 1'b1;
            end
        end
    end

    // percent = floor(v*100 / (2^n-1)): shift estimate, then one correction
    assign scaled     = PROD_BITS'(held_value_next) * PROD_BITS'(PERCENT_SCALE);
    assign pct_coarse = scaled[PROD_BITS-1:SAMPLE_BITS];
    assign pct_rem    = REM_BITS'(scaled[SAMPLE_BITS-1:0]) + REM_BITS'(pct_coarse);

    always_comb
    begin
        pct_next = pct_coarse;
        if (pct_rem >= REM_BITS'(FULL_SCALE))
        begin
            pct_next = pct_coarse + 1'b1;
        end
        if (pct_next > PERCENT_MAX)
        begin
            pct_next = PERCENT_MAX;
        end
    end

    // state and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_value_reg <= '0;
            held_valid_reg <= 1'b0;
            pending_reg    <= 1'b0;
            change_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            held_value_reg <= held_value_next;
            held_valid_reg <= held_valid_next;
            pending_reg    <= pending_next;
            change_reg     <= change_next;
            if (sample_acc)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (sample_acc)
        begin
            out_held_reg    <= held_value_next;
            out_rvalid_reg  <= held_valid_next;
            out_changed_reg <= change_next;
            out_percent_reg <= pct_next;
        end
    end

    assign result_ch.valid         = out_valid_reg;
    assign result_ch.held_reading  = out_held_reg;
    assign result_ch.reading_valid = out_rvalid_reg;
    assign result_ch.changed       = out_changed_reg;
    assign result_ch.percent       = out_percent_reg;

`ifndef SYNTHESIS
    // a clear beat leaves the changed flag low
    assert property (@(posedge clk) disable iff (!rst_n)
        clear_acc |=> !change_reg)
        else $error("changed flag survived a clear beat");

    // a pending jump only exists once a value is held
    assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg |-> held_valid_reg)
        else $error("jump pending without a held value");

    // the confirming sample always ends the pending jump
    assert property (@(posedge clk) disable iff (!rst_n)
        (sample_acc && pending_reg) |=> (!pending_reg && change_reg))
        else $error("confirming sample not adopted");

    // a result appears only after a sample beat
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(sample_acc))
        else $error("result without a sample beat");

    // an empty reading shows zero value and zero percent
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_rvalid_reg) |-> (out_held_reg == '0 && out_percent_reg == '0))
        else $error("nonzero reading while nothing is held");
`endif

endmodule
